@@ design/mcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcrc_pkg
// constants, mode codes and crc fold functions for the multi-mode crc engine
// ----------------------------------------------------------------------------
package mcrc_pkg;

    localparam int DATA_W      = 32;
    localparam int CRC_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int HALF_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam mode_t MODE_REFL32 = 2'd0;
    localparam mode_t MODE_ARC16  = 2'd1;
    localparam mode_t MODE_WORD32 = 2'd2;

    localparam cfg_index_t REG_CRC_MODE  = 2'd0;
    localparam cfg_index_t REG_WORD_POLY = 2'd1;

    localparam crc_t CRC32_REFL_POLY = 32'hEDB8_8320;
    localparam crc_t CRC16_ARC_POLY  = 32'h0000_A001;
    localparam crc_t ALL_ONES32      = 32'hFFFF_FFFF;
    localparam crc_t WORD_POLY_RESET = 32'h04C1_1DB7;

    // reflected fold of one byte, lsb first
    function automatic crc_t fold_byte_reflected(crc_t crc, logic [BYTE_W-1:0] b,
                                                 crc_t poly);
        crc_t c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // msb-first fold of one word
    function automatic crc_t fold_word_msb(crc_t crc, data_t w, crc_t poly);
        crc_t c;
        logic fb;
        c  = crc;
        fb = 1'b0;
        for (int k = DATA_W-1; k >= 0; k--)
        begin
            fb = c[CRC_W-1] ^ w[k];
            c  = c << 1;
            if (fb)
                c = c ^ poly;
        end
        return c;
    endfunction

endpackage

@@ design/multi_mode_crc_engine_top.sv @@
// ----------------------------------------------------------------------------
// multi_mode_crc_engine_top
// running crc engine: reflected crc-32, crc-16/arc or programmable word crc-32
// ----------------------------------------------------------------------------
// an accepted input word waits in the input stage register; it is folded into the
//   running crc and the result register when the output stage is free or m_tready is high
// throughput: one word per cycle while the output stage is free or m_tready is high, set by
//   the combinational crc fold on the input stage feeding the running crc register
// reset: rst_n async low; crc register to all ones, mode 0, word polynomial
//   0x04c11db7, both pipeline stages empty
module multi_mode_crc_engine_top
    import mcrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [31:0] data_in
    input  logic                   s_tuser,   // [0] start_req
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CRC_W-1:0]       m_tdata,   // [31:0] crc_out
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    mode_t mode_reg;
    crc_t  poly_reg;
    crc_t  crc_reg;
    crc_t  crc_next;
    crc_t  res_next;
    crc_t  out_reg;
    logic  out_valid_reg;
    logic  s1_valid_reg;
    data_t s1_data_reg;
    logic  s1_start_reg;
    logic  advance;
    crc_t  base;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_REFL32;
            poly_reg <= WORD_POLY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CRC_MODE)
                mode_reg <= cfg_data[MODE_W-1:0];
            else if (cfg_index == REG_WORD_POLY)
                poly_reg <= cfg_data;
        end
    end

    always_comb
    begin
        base     = crc_reg;
        crc_next = crc_reg;
        res_next = crc_reg;
        unique case (mode_reg)
            MODE_REFL32:
            begin
                base     = s1_start_reg ? ALL_ONES32 : crc_reg;
                crc_next = fold_byte_reflected(base, s1_data_reg[BYTE_W-1:0],
                                               CRC32_REFL_POLY);
                res_next = crc_next ^ ALL_ONES32;
            end
            MODE_ARC16:
            begin
                base     = s1_start_reg ? '0 : {{(CRC_W-HALF_W){1'b0}}, crc_reg[HALF_W-1:0]};
                crc_next = fold_byte_reflected(base, s1_data_reg[BYTE_W-1:0],
                                               CRC16_ARC_POLY);
                crc_next = {{(CRC_W-HALF_W){1'b0}}, crc_next[HALF_W-1:0]};
                res_next = crc_next;
            end
            MODE_WORD32:
            begin
                base     = s1_start_reg ? ALL_ONES32 : crc_reg;
                crc_next = fold_word_msb(base, s1_data_reg, poly_reg);
                res_next = crc_next;
            end
            default:
            begin
                crc_next = crc_reg;
                res_next = crc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= ALL_ONES32;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (advance)
            begin
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_data_reg  <= s_tdata;
            s1_start_reg <= s_tuser;
        end
        if (advance)
            out_reg <= res_next;
    end

    // input stage blocks while the result waits
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while both stages are full");

    // arc mode keeps the upper half of the crc clear
    a_arc_upper_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode_reg == MODE_ARC16 |=> crc_reg[CRC_W-1:HALF_W] == '0)
        else $error("arc fold left upper crc bits set");

    // word mode shows the running crc unchanged
    a_word_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode_reg == MODE_WORD32 |=> m_tvalid && m_tdata == crc_reg)
        else $error("word mode result differs from crc register");

endmodule
